// ===== rtl/sbi_pkg.sv =====
// Shared types and constants for the segment / bisector intersection block.
// Depends on nothing; every RTL file imports it.
`default_nettype none
package sbi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_COORDS      = 3;
    localparam logic [1:0] DIM_RESET = 2'd3;

    typedef struct packed {
        logic signed [31:0] seg_a_x;
        logic signed [31:0] seg_a_y;
        logic signed [31:0] seg_a_z;
        logic signed [31:0] seg_b_x;
        logic signed [31:0] seg_b_y;
        logic signed [31:0] seg_b_z;
        logic signed [31:0] site_a_x;
        logic signed [31:0] site_a_y;
        logic signed [31:0] site_a_z;
        logic signed [31:0] site_b_x;
        logic signed [31:0] site_b_y;
        logic signed [31:0] site_b_z;
    } sbi_req_t;

    typedef struct packed {
        logic signed [31:0] cross_x;
        logic signed [31:0] cross_y;
        logic signed [31:0] cross_z;
    } sbi_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/segment_bisector_intersection.sv =====
// Pipelined segment / perpendicular-bisector intersection, signed fixed point.
// Depends on sbi_pkg for the beat structs and defaults.
`default_nettype none
// Usage
//   req channel: req_valid / req_stall / req carry one query per beat (segment
//   endpoints and two sites). rsp channel: rsp_valid / rsp_stall / rsp carry
//   the intersection point. A beat moves on a rising edge with valid high and
//   stall low.
//   cfg_we / cfg_wdata write dim (coordinates in use); write it only while the
//   pipeline is empty. Coordinates at index dim and above come out as zero.
// Pipeline depth and throughput
//   A beat passes from req to rsp through seven arithmetic
//   stages (differences, products, sums, weights, partial products, numerator,
//   magnitude), one restoring divider stage per quotient bit, one output
//   register. One beat enters every cycle unless rsp_stall holds the output;
//   the per-bit divider stages set the depth.
// Reset and stall
//   rst_n clears every stage valid bit and sets dim to 3.
//   When the output beat is held by rsp_stall, the whole pipeline holds and
//   req_stall goes high; nothing is dropped or repeated. Empty stages do not
//   hold the pipe, so req is taken while the pipe still fills.
module segment_bisector_intersection #(
    parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire sbi_pkg::sbi_req_t req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output sbi_pkg::sbi_rsp_t     rsp,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_wdata
);
    import sbi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int NC  = NUM_COORDS;
    localparam int PW  = 2 * W + 2;   // signed product width
    localparam int AW  = 2 * W + 5;   // signed accumulator width
    localparam int LW  = 2 * W + 4;   // weight magnitude width
    localparam int DW  = LW + 1;      // divisor width
    localparam int NMW = 3 * W + 4;   // numerator magnitude width
    localparam int NW  = NMW + 1;     // signed numerator width

    typedef struct packed {
        logic          vld;
        logic [DW-1:0] rem;
        logic [W-1:0]  num;
        logic [W-1:0]  quo;
        logic [DW-1:0] den;
        logic          neg;
    } div_stage_t;

    logic [1:0] dim_reg;
    logic       adv;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dim_reg <= DIM_RESET;
        else if (cfg_we)
            dim_reg <= cfg_wdata;
    end

    // Advance the whole pipe unless the output beat is held
    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;

    // Unpack the request beat into coordinate arrays, low W bits only
    logic signed [W-1:0] in_qa [NC];
    logic signed [W-1:0] in_qb [NC];
    logic signed [W-1:0] in_pa [NC];
    logic signed [W-1:0] in_pb [NC];

    always_comb
    begin
        in_qa[0] = req.seg_a_x[W-1:0];  in_qa[1] = req.seg_a_y[W-1:0];
        in_qa[2] = req.seg_a_z[W-1:0];
        in_qb[0] = req.seg_b_x[W-1:0];  in_qb[1] = req.seg_b_y[W-1:0];
        in_qb[2] = req.seg_b_z[W-1:0];
        in_pa[0] = req.site_a_x[W-1:0]; in_pa[1] = req.site_a_y[W-1:0];
        in_pa[2] = req.site_a_z[W-1:0];
        in_pb[0] = req.site_b_x[W-1:0]; in_pb[1] = req.site_b_y[W-1:0];
        in_pb[2] = req.site_b_z[W-1:0];
    end

    // Stage 1: normal n = p1 - p2, sum s = p1 + p2, doubled endpoints
    logic                s1_vld_reg;
    logic [NC-1:0]       s1_use_reg;
    logic signed [W:0]   s1_n_reg  [NC];
    logic signed [W:0]   s1_s_reg  [NC];
    logic signed [W:0]   s1_a2_reg [NC];
    logic signed [W:0]   s1_b2_reg [NC];
    logic signed [W-1:0] s1_qa_reg [NC];
    logic signed [W-1:0] s1_qb_reg [NC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NC; c++)
            begin
                s1_use_reg[c] <= (2'(c) < dim_reg);
                s1_n_reg[c]   <= (W+1)'(in_pa[c]) - (W+1)'(in_pb[c]);
                s1_s_reg[c]   <= (W+1)'(in_pa[c]) + (W+1)'(in_pb[c]);
                s1_a2_reg[c]  <= $signed({in_qa[c], 1'b0});
                s1_b2_reg[c]  <= $signed({in_qb[c], 1'b0});
                s1_qa_reg[c]  <= in_qa[c];
                s1_qb_reg[c]  <= in_qb[c];
            end
        end
    end

    // Stage 2: products per coordinate, zero for unused coordinates
    logic                 s2_vld_reg;
    logic [NC-1:0]        s2_use_reg;
    logic signed [PW-1:0] s2_ns_reg [NC];
    logic signed [PW-1:0] s2_t1_reg [NC];
    logic signed [PW-1:0] s2_t2_reg [NC];
    logic signed [W-1:0]  s2_qa_reg [NC];
    logic signed [W-1:0]  s2_qb_reg [NC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_use_reg <= s1_use_reg;
            for (int c = 0; c < NC; c++)
            begin
                if (s1_use_reg[c])
                begin
                    s2_ns_reg[c] <= PW'(s1_n_reg[c]) * PW'(s1_s_reg[c]);
                    s2_t1_reg[c] <= PW'(s1_b2_reg[c]) * PW'(s1_n_reg[c]);
                    s2_t2_reg[c] <= PW'(s1_a2_reg[c]) * PW'(s1_n_reg[c]);
                end
                else
                begin
                    s2_ns_reg[c] <= '0;
                    s2_t1_reg[c] <= '0;
                    s2_t2_reg[c] <= '0;
                end
                s2_qa_reg[c] <= s1_qa_reg[c];
                s2_qb_reg[c] <= s1_qb_reg[c];
            end
        end
    end

    // Stage 3: doubled plane distances of both endpoints
    logic                 s3_vld_reg;
    logic [NC-1:0]        s3_use_reg;
    logic signed [AW-1:0] s3_acc1_reg, s3_acc2_reg;
    logic signed [AW-1:0] acc1_next, acc2_next;
    logic signed [W-1:0]  s3_qa_reg [NC];
    logic signed [W-1:0]  s3_qb_reg [NC];

    always_comb
    begin
        acc1_next = '0;
        acc2_next = '0;
        for (int c = 0; c < NC; c++)
        begin
            acc1_next = acc1_next + AW'(s2_t1_reg[c]) - AW'(s2_ns_reg[c]);
            acc2_next = acc2_next + AW'(s2_t2_reg[c]) - AW'(s2_ns_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (adv)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_use_reg  <= s2_use_reg;
            s3_acc1_reg <= acc1_next;
            s3_acc2_reg <= acc2_next;
            for (int c = 0; c < NC; c++)
            begin
                s3_qa_reg[c] <= s2_qa_reg[c];
                s3_qb_reg[c] <= s2_qb_reg[c];
            end
        end
    end

    // Stage 4: weight magnitudes and divisor; equal halves on a zero sum
    logic                s4_vld_reg;
    logic [NC-1:0]       s4_use_reg;
    logic [LW-1:0]       s4_l1_reg, s4_l2_reg;
    logic [DW-1:0]       s4_den_reg;
    logic [W-1:0]        s4_qam_reg [NC];
    logic [W-1:0]        s4_qbm_reg [NC];
    logic [NC-1:0]       s4_qan_reg, s4_qbn_reg;
    logic [LW-1:0]       l1_next, l2_next;
    logic [DW-1:0]       den_next;

    always_comb
    begin
        l1_next  = s3_acc1_reg[AW-1] ? LW'(-s3_acc1_reg) : LW'(s3_acc1_reg);
        l2_next  = s3_acc2_reg[AW-1] ? LW'(-s3_acc2_reg) : LW'(s3_acc2_reg);
        den_next = DW'(l1_next) + DW'(l2_next);
        if (den_next == '0)
        begin
            l1_next  = LW'(1);
            l2_next  = LW'(1);
            den_next = DW'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (adv)
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_use_reg <= s3_use_reg;
            s4_l1_reg  <= l1_next;
            s4_l2_reg  <= l2_next;
            s4_den_reg <= den_next;
            for (int c = 0; c < NC; c++)
            begin
                s4_qan_reg[c] <= s3_qa_reg[c][W-1];
                s4_qbn_reg[c] <= s3_qb_reg[c][W-1];
                s4_qam_reg[c] <= s3_qa_reg[c][W-1] ? W'(-s3_qa_reg[c]) : W'(s3_qa_reg[c]);
                s4_qbm_reg[c] <= s3_qb_reg[c][W-1] ? W'(-s3_qb_reg[c]) : W'(s3_qb_reg[c]);
            end
        end
    end

    // Stage 5: weight times coordinate, as partial products of W-bit weight slices
    logic               s5_vld_reg;
    logic [NC-1:0]      s5_use_reg;
    logic [DW-1:0]      s5_den_reg;
    logic [NC-1:0]      s5_qan_reg, s5_qbn_reg;
    logic [2*W-1:0]     s5_pp1_reg [NC][3];
    logic [2*W-1:0]     s5_pp2_reg [NC][3];
    logic [3*W-1:0]     l1_ext, l2_ext;

    assign l1_ext = (3*W)'(s4_l1_reg);
    assign l2_ext = (3*W)'(s4_l2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (adv)
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_use_reg <= s4_use_reg;
            s5_den_reg <= s4_den_reg;
            s5_qan_reg <= s4_qan_reg;
            s5_qbn_reg <= s4_qbn_reg;
            for (int c = 0; c < NC; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s5_pp1_reg[c][k] <= (2*W)'(l1_ext[k*W +: W]) * (2*W)'(s4_qam_reg[c]);
                    s5_pp2_reg[c][k] <= (2*W)'(l2_ext[k*W +: W]) * (2*W)'(s4_qbm_reg[c]);
                end
            end
        end
    end

    // Stage 6: signed numerator per coordinate
    logic                s6_vld_reg;
    logic [NC-1:0]       s6_use_reg;
    logic [DW-1:0]       s6_den_reg;
    logic signed [NW-1:0] s6_num_reg [NC];
    logic signed [NW-1:0] num_next   [NC];
    logic [NMW-1:0]      m1 [NC];
    logic [NMW-1:0]      m2 [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            m1[c] = NMW'(s5_pp1_reg[c][0]) + (NMW'(s5_pp1_reg[c][1]) << W)
                  + (NMW'(s5_pp1_reg[c][2]) << (2*W));
            m2[c] = NMW'(s5_pp2_reg[c][0]) + (NMW'(s5_pp2_reg[c][1]) << W)
                  + (NMW'(s5_pp2_reg[c][2]) << (2*W));
            num_next[c] = (s5_qan_reg[c] ? -$signed({1'b0, m1[c]}) : $signed({1'b0, m1[c]}))
                        + (s5_qbn_reg[c] ? -$signed({1'b0, m2[c]}) : $signed({1'b0, m2[c]}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (adv)
            s6_vld_reg <= s5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_use_reg <= s5_use_reg;
            s6_den_reg <= s5_den_reg;
            for (int c = 0; c < NC; c++)
                s6_num_reg[c] <= num_next[c];
        end
    end

    // Stage 7: numerator magnitude; load the divider remainder with its top
    logic [NC-1:0]   s7_use_reg;
    div_stage_t      s7_reg [NC];
    logic [NMW-1:0]  nmag [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
            nmag[c] = s6_num_reg[c][NW-1] ? NMW'(-s6_num_reg[c]) : NMW'(s6_num_reg[c]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
                s7_reg[c] <= '0;
        end
        else if (adv)
        begin
            for (int c = 0; c < NC; c++)
            begin
                s7_reg[c].vld <= s6_vld_reg;
                s7_reg[c].rem <= DW'(nmag[c][NMW-1:W]);
                s7_reg[c].num <= nmag[c][W-1:0];
                s7_reg[c].quo <= '0;
                s7_reg[c].den <= s6_den_reg;
                s7_reg[c].neg <= s6_num_reg[c][NW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s7_use_reg <= s6_use_reg;
    end

    // Divider: one quotient bit per stage, use mask travels alongside
    div_stage_t    dv_reg     [W][NC];
    div_stage_t    dv_next    [W][NC];
    logic [NC-1:0] dv_use_reg [W];

    for (genvar i = 0; i < W; i++)
    begin : g_div
        for (genvar c = 0; c < NC; c++)
        begin : g_lane
            div_stage_t  prev;
            logic [DW:0] rem2;
            logic        ge;

            assign prev = (i == 0) ? s7_reg[c] : dv_reg[(i == 0) ? 0 : i-1][c];
            assign rem2 = {prev.rem, prev.num[W-1]};
            assign ge   = (rem2 >= {1'b0, prev.den});

            always_comb
            begin
                dv_next[i][c]     = prev;
                dv_next[i][c].rem = ge ? DW'(rem2 - {1'b0, prev.den}) : DW'(rem2);
                dv_next[i][c].num = prev.num << 1;
                dv_next[i][c].quo = {prev.quo[W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[i][c] <= '0;
                else if (adv)
                    dv_reg[i][c] <= dv_next[i][c];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_use_reg[i] <= (i == 0) ? s7_use_reg : dv_use_reg[(i == 0) ? 0 : i-1];
        end
    end

    // Output register: apply sign, zero unused coordinates
    logic               rsp_vld_reg;
    sbi_rsp_t           rsp_reg;
    logic signed [31:0] res_next [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (dv_use_reg[W-1][c])
                res_next[c] = 32'(signed'(dv_reg[W-1][c].neg ? -dv_reg[W-1][c].quo
                                                             :  dv_reg[W-1][c].quo));
            else
                res_next[c] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (adv)
            rsp_vld_reg <= dv_reg[W-1][0].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg.cross_x <= res_next[0];
            rsp_reg.cross_y <= res_next[1];
            rsp_reg.cross_z <= res_next[2];
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
